// ===== rtl/tfn_pkg.sv =====
package tfn_pkg;

  // Input coordinates are signed Q8.8 at this width.
  localparam int COORD_WIDTH = 16;
  // Default number of fraction bits of the unit normal.
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  // Output components are signed at this width.
  localparam int OUT_WIDTH = 16;
  // The cross product is normalized so that its largest magnitude has this many bits.
  localparam int NORM_BITS = 30;
  // Sum of three squares of normalized magnitudes, and its square root.
  localparam int SUM_W = 2 * NORM_BITS + 2;
  localparam int ROOT_W = NORM_BITS + 1;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIR_W = 3;

  localparam logic [DIR_W-1:0] DIR_FRONT  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_BACK   = 3'd1;
  localparam logic [DIR_W-1:0] DIR_TOP    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd3;
  localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd4;
  localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd5;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by_coord;
    logic signed [COORD_WIDTH-1:0] bz;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic [DIR_W-1:0]              direction;
  } tri_req_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] normal_x;
    logic signed [OUT_WIDTH-1:0] normal_y;
    logic signed [OUT_WIDTH-1:0] normal_z;
    logic                        degenerate;
  } tri_res_t;

  // Per-request bookkeeping that travels beside the arithmetic chains.
  typedef struct packed {
    logic       valid;
    logic       axis;
    logic       degen;
    logic [2:0] neg;
    tri_res_t   axis_res;
  } side_t;

  // Working state of one square-root step.
  typedef struct packed {
    logic [SUM_W-1:0] x;
    logic [SUM_W-1:0] r;
  } sqrt_st_t;

endpackage

// ===== rtl/tfn_norm_cell.sv =====
module tfn_norm_cell #(
  parameter int W  = 33,
  parameter int SH = 1
) (
  input  logic                clk,
  input  logic [W-1:0]        o_in,
  input  logic [2:0][W-1:0]   mag_in,
  output logic [W-1:0]        o_out,
  output logic [2:0][W-1:0]   mag_out
);

  logic zero_top;

  // When the top SH bits of the combined word are clear, all three move up by SH.
  assign zero_top = (o_in[W-1 -: SH] == '0);

  always_ff @(posedge clk) begin
    if (zero_top) begin
      o_out <= o_in << SH;
      for (int i = 0; i < 3; i++) mag_out[i] <= mag_in[i] << SH;
    end else begin
      o_out   <= o_in;
      mag_out <= mag_in;
    end
  end

endmodule

// ===== rtl/tfn_sqrt_cell.sv =====
module tfn_sqrt_cell
  import tfn_pkg::*;
#(
  parameter int BIT_POS = 0
) (
  input  logic                clk,
  input  tfn_pkg::sqrt_st_t   st_in,
  output tfn_pkg::sqrt_st_t   st_out
);

  localparam logic [SUM_W-1:0] BIT_VAL = SUM_W'(1) << BIT_POS;

  logic [SUM_W-1:0] trial;

  assign trial = st_in.r + BIT_VAL;

  always_ff @(posedge clk) begin
    if (st_in.x >= trial) begin
      st_out.x <= st_in.x - trial;
      st_out.r <= (st_in.r >> 1) + BIT_VAL;
    end else begin
      st_out.x <= st_in.x;
      st_out.r <= st_in.r >> 1;
    end
  end

endmodule

// ===== rtl/tfn_div_cell.sv =====
module tfn_div_cell
  import tfn_pkg::*;
#(
  parameter int QW = 15
) (
  input  logic                         clk,
  input  logic [ROOT_W-1:0]            den_in,
  input  logic [2:0][ROOT_W-1:0]       rem_in,
  input  logic [2:0][QW-1:0]           nq_in,
  output logic [ROOT_W-1:0]            den_out,
  output logic [2:0][ROOT_W-1:0]       rem_out,
  output logic [2:0][QW-1:0]           nq_out
);

  logic [2:0][ROOT_W:0] trial;
  logic [2:0]           ge;

  // One restoring step per component: the next numerator bit comes off the top of
  // nq, the quotient bit goes in at the bottom.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_in[i], nq_in[i][QW-1]};
      ge[i]    = (trial[i] >= {1'b0, den_in});
    end
  end

  always_ff @(posedge clk) begin
    den_out <= den_in;
    for (int i = 0; i < 3; i++) begin
      if (ge[i]) rem_out[i] <= ROOT_W'(trial[i] - {1'b0, den_in});
      else       rem_out[i] <= trial[i][ROOT_W-1:0];
      nq_out[i] <= {nq_in[i][QW-2:0], ge[i]};
    end
  end

endmodule

// ===== rtl/triangle_face_normal.sv =====
// Triangle face normal. Each request carries three vertices A, B, C in signed Q8.8
// and a direction code. Codes front, back, top, bottom, left and right give the
// fixed axis normals +Z, -Z, +Y, -Y, -X and +X; codes 6 and 7 compute the unit
// vector of cross(C-A, B-A) in signed Q1.NORMAL_FRAC_BITS, saturated at one. For
// codes 6 and 7, a cross product of zero gives a zero vector with degenerate set.
// The block is a fixed-latency pipeline that takes one request in every cycle:
// busy is always low, and every request gives exactly one result, in order, shown
// for a single cycle with done high. The receiver cannot stall the block, so it
// must take each result in the cycle it appears. Latency is the same for every
// request, axis codes included: four front stages (input, edges, products, cross
// product), one magnitude stage, a chain of normalizing shift cells (six at the
// default coordinate width), a squares and a sum stage, a chain of 31 square root
// cells (one root bit each), a numerator stage, a chain of NORMAL_FRAC_BITS+1
// divider cells (one quotient bit each) and the output register. Throughput is one
// triangle per cycle.
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tfn_pkg::tri_req_t req,
  output logic              done,
  output tfn_pkg::tri_res_t res
);

  localparam int F          = NORMAL_FRAC_BITS;
  localparam int QW         = F + 1;
  localparam int NUMW       = NORM_BITS + F + 1;
  localparam int DIFF_W     = COORD_WIDTH + 1;
  localparam int DIFF_SHIFT = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
  localparam int EW         = DIFF_W - DIFF_SHIFT;
  localparam int CRW        = 2 * EW;
  localparam int MW         = 2 * EW - 1;
  localparam int NSTEPS     = $clog2(MW);
  localparam int SIDE_LEN   = NSTEPS + 4 + SQRT_STEPS + QW;
  localparam int MAG_LEN    = 2 + SQRT_STEPS;
  localparam longint ONE_RAW = longint'(64'd1 << F);
  localparam longint ONE_INT = (ONE_RAW > 32767) ? 32767 : ONE_RAW;
  localparam logic [QW-1:0]        ONE_Q   = QW'(ONE_INT);
  localparam logic [OUT_WIDTH-1:0] ONE_OUT = OUT_WIDTH'(ONE_INT);

  // The pipeline never holds a request back.
  assign busy = 1'b0;

  // Input register.
  logic     s1_valid;
  tri_req_t s1_req;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= start && !busy;
    if (start && !busy) s1_req <= req;
  end

  // Edge vectors e1 = C - A and e2 = B - A. Above 30 coordinate bits the
  // magnitudes are cut back, truncating toward zero.
  logic signed [EW-1:0] e1_next [3];
  logic signed [EW-1:0] e2_next [3];

  // Sign extension into DIFF_W is explicit: the coordinates are signed.
  logic signed [DIFF_W-1:0] d1s [3];
  logic signed [DIFF_W-1:0] d2s [3];

  always_comb begin
    d1s[0] = {s1_req.cx[COORD_WIDTH-1], s1_req.cx} - {s1_req.ax[COORD_WIDTH-1], s1_req.ax};
    d1s[1] = {s1_req.cy[COORD_WIDTH-1], s1_req.cy} - {s1_req.ay[COORD_WIDTH-1], s1_req.ay};
    d1s[2] = {s1_req.cz[COORD_WIDTH-1], s1_req.cz} - {s1_req.az[COORD_WIDTH-1], s1_req.az};
    d2s[0] = {s1_req.bx[COORD_WIDTH-1], s1_req.bx} - {s1_req.ax[COORD_WIDTH-1], s1_req.ax};
    d2s[1] = {s1_req.by_coord[COORD_WIDTH-1], s1_req.by_coord}
             - {s1_req.ay[COORD_WIDTH-1], s1_req.ay};
    d2s[2] = {s1_req.bz[COORD_WIDTH-1], s1_req.bz} - {s1_req.az[COORD_WIDTH-1], s1_req.az};
  end

  generate
    if (DIFF_SHIFT == 0) begin : g_edge_exact
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          e1_next[i] = EW'(d1s[i]);
          e2_next[i] = EW'(d2s[i]);
        end
      end
    end else begin : g_edge_cut
      logic [DIFF_W-1:0] a1, a2;
      logic [EW-1:0]     m1, m2;
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          a1 = d1s[i][DIFF_W-1] ? DIFF_W'(-d1s[i]) : DIFF_W'(d1s[i]);
          a2 = d2s[i][DIFF_W-1] ? DIFF_W'(-d2s[i]) : DIFF_W'(d2s[i]);
          m1 = EW'(a1 >> DIFF_SHIFT);
          m2 = EW'(a2 >> DIFF_SHIFT);
          e1_next[i] = d1s[i][DIFF_W-1] ? EW'(-m1) : m1;
          e2_next[i] = d2s[i][DIFF_W-1] ? EW'(-m2) : m2;
        end
      end
    end
  endgenerate

  logic                   s2_valid;
  logic [DIR_W-1:0]       s2_dir;
  logic signed [EW-1:0]   e1 [3];
  logic signed [EW-1:0]   e2 [3];

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    s2_dir <= s1_req.direction;
    for (int i = 0; i < 3; i++) begin
      e1[i] <= e1_next[i];
      e2[i] <= e2_next[i];
    end
  end

  // Six independent products for the cross product.
  logic                   s3_valid;
  logic [DIR_W-1:0]       s3_dir;
  logic signed [CRW-1:0]  p [6];

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
    s3_dir <= s2_dir;
    p[0] <= CRW'(e1[1] * e2[2]);
    p[1] <= CRW'(e1[2] * e2[1]);
    p[2] <= CRW'(e1[2] * e2[0]);
    p[3] <= CRW'(e1[0] * e2[2]);
    p[4] <= CRW'(e1[0] * e2[1]);
    p[5] <= CRW'(e1[1] * e2[0]);
  end

  logic                   s4_valid;
  logic [DIR_W-1:0]       s4_dir;
  logic signed [CRW-1:0]  cr [3];

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else     s4_valid <= s3_valid;
    s4_dir <= s3_dir;
    cr[0]  <= p[0] - p[1];
    cr[1]  <= p[2] - p[3];
    cr[2]  <= p[4] - p[5];
  end

  // Magnitudes of the cross product, plus the bookkeeping for this request.
  side_t side_next;

  always_comb begin
    side_next          = '0;
    side_next.valid    = s4_valid;
    side_next.axis     = (s4_dir <= DIR_RIGHT);
    side_next.degen    = (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
    side_next.neg      = {cr[2][CRW-1], cr[1][CRW-1], cr[0][CRW-1]};
    unique case (s4_dir)
      DIR_FRONT:  side_next.axis_res.normal_z = ONE_OUT;
      DIR_BACK:   side_next.axis_res.normal_z = OUT_WIDTH'(-ONE_OUT);
      DIR_TOP:    side_next.axis_res.normal_y = ONE_OUT;
      DIR_BOTTOM: side_next.axis_res.normal_y = OUT_WIDTH'(-ONE_OUT);
      DIR_LEFT:   side_next.axis_res.normal_x = OUT_WIDTH'(-ONE_OUT);
      DIR_RIGHT:  side_next.axis_res.normal_x = ONE_OUT;
      default:    side_next.axis_res = '0;
    endcase
  end

  logic [2:0][MW-1:0] mag5;
  side_t              side_d [SIDE_LEN];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag5[i] <= cr[i][CRW-1] ? MW'(-cr[i]) : MW'(cr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIDE_LEN; i++) side_d[i] <= '0;
    end else begin
      side_d[0] <= side_next;
      for (int i = 1; i < SIDE_LEN; i++) side_d[i] <= side_d[i-1];
    end
  end

  // Normalizing chain: the OR of the magnitudes has the same leading one as the
  // largest of them, so each cell shifts all three by a power of two while the
  // top of that word is clear.
  logic [MW-1:0]       nrm_o   [NSTEPS+1];
  logic [2:0][MW-1:0]  nrm_mag [NSTEPS+1];

  assign nrm_o[0]   = mag5[0] | mag5[1] | mag5[2];
  assign nrm_mag[0] = mag5;

  generate
    for (genvar k = 0; k < NSTEPS; k++) begin : g_norm
      tfn_norm_cell #(
        .W  (MW),
        .SH (1 << (NSTEPS - 1 - k))
      ) u_cell (
        .clk     (clk),
        .o_in    (nrm_o[k]),
        .mag_in  (nrm_mag[k]),
        .o_out   (nrm_o[k+1]),
        .mag_out (nrm_mag[k+1])
      );
    end
  endgenerate

  // Keep the top NORM_BITS bits; dropping the low bits truncates toward zero.
  logic [2:0][NORM_BITS-1:0] nmag;

  generate
    if (MW >= NORM_BITS) begin : g_take_top
      always_comb begin
        for (int i = 0; i < 3; i++) nmag[i] = nrm_mag[NSTEPS][i][MW-1 -: NORM_BITS];
      end
    end else begin : g_pad_low
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          nmag[i] = {nrm_mag[NSTEPS][i], {(NORM_BITS - MW){1'b0}}};
        end
      end
    end
  endgenerate

  // Squares, then their sum.
  logic [2*NORM_BITS-1:0]     sq [3];
  logic [SUM_W-1:0]           sum;
  logic [2:0][NORM_BITS-1:0]  mag_d [MAG_LEN];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sq[i] <= nmag[i] * nmag[i];
    sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    mag_d[0] <= nmag;
    for (int i = 1; i < MAG_LEN; i++) mag_d[i] <= mag_d[i-1];
  end

  // Square root chain, one root bit per cell.
  sqrt_st_t sq_st [SQRT_STEPS+1];

  assign sq_st[0].x = sum;
  assign sq_st[0].r = '0;

  generate
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      tfn_sqrt_cell #(
        .BIT_POS (2 * (SQRT_STEPS - 1 - k))
      ) u_cell (
        .clk    (clk),
        .st_in  (sq_st[k]),
        .st_out (sq_st[k+1])
      );
    end
  endgenerate

  // Rounded numerators; for a triangle that is not degenerate the length is never
  // zero because the largest normalized magnitude has its top bit set.
  logic [ROOT_W-1:0]  len;
  logic [NUMW-1:0]    num [3];
  logic [ROOT_W-1:0]  den0;

  assign len = sq_st[SQRT_STEPS].r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    den0 <= len;
    for (int i = 0; i < 3; i++) begin
      num[i] <= NUMW'({mag_d[MAG_LEN-1][i], {F{1'b0}}}) + NUMW'(len[ROOT_W-1:1]);
    end
  end

  // Divider chain, one quotient bit per cell for all three components.
  logic [ROOT_W-1:0]       dv_den [QW+1];
  logic [2:0][ROOT_W-1:0]  dv_rem [QW+1];
  logic [2:0][QW-1:0]      dv_nq  [QW+1];

  always_comb begin
    dv_den[0] = den0;
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = ROOT_W'(num[i][NUMW-1:QW]);
      dv_nq[0][i]  = num[i][QW-1:0];
    end
  end

  generate
    for (genvar k = 0; k < QW; k++) begin : g_div
      tfn_div_cell #(
        .QW (QW)
      ) u_cell (
        .clk     (clk),
        .den_in  (dv_den[k]),
        .rem_in  (dv_rem[k]),
        .nq_in   (dv_nq[k]),
        .den_out (dv_den[k+1]),
        .rem_out (dv_rem[k+1]),
        .nq_out  (dv_nq[k+1])
      );
    end
  endgenerate

  // Saturate at one, apply the signs, and pick axis, degenerate or computed.
  side_t                 side_o;
  logic [QW-1:0]         qs [3];
  logic [OUT_WIDTH-1:0]  comp [3];
  tri_res_t              res_next;

  assign side_o = side_d[SIDE_LEN-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i]   = (dv_nq[QW][i] > ONE_Q) ? ONE_Q : dv_nq[QW][i];
      comp[i] = side_o.neg[i] ? OUT_WIDTH'(-OUT_WIDTH'(qs[i])) : OUT_WIDTH'(qs[i]);
    end
    priority if (side_o.axis) begin
      res_next = side_o.axis_res;
    end else if (side_o.degen) begin
      res_next            = '0;
      res_next.degenerate = 1'b1;
    end else begin
      res_next.normal_x   = comp[0];
      res_next.normal_y   = comp[1];
      res_next.normal_z   = comp[2];
      res_next.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= side_o.valid;
    res <= res_next;
  end

endmodule

// ===== verif/normal_checker.sv =====
`timescale 1ns / 100ps

module normal_checker
  import tfn_pkg::*;
#(
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  tri_req_t req,
  input  logic     done,
  input  tri_res_t res,
  output int       errors,
  output int       pending
);

  localparam longint ONE_RAW = longint'(1) << NORMAL_FRAC_BITS;
  localparam longint UNIT = (ONE_RAW > 32767) ? 32767 : ONE_RAW;

  tri_res_t expected_normals[$];

  function automatic logic [OUT_WIDTH-1:0] signed_field(bit neg, longint mag);
    longint v;
    v = neg ? -mag : mag;
    return v[OUT_WIDTH-1:0];
  endfunction

  function automatic longint root_floor(longint x);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic tri_res_t face_normal(tri_req_t t);
    tri_res_t o;
    longint e1[3], e2[3], cr[3], mag[3], m, sum, len, q;
    bit neg[3];
    int bl;
    o = '0;
    case (t.direction)
      DIR_FRONT:  o.normal_z = signed_field(0, UNIT);
      DIR_BACK:   o.normal_z = signed_field(1, UNIT);
      DIR_TOP:    o.normal_y = signed_field(0, UNIT);
      DIR_BOTTOM: o.normal_y = signed_field(1, UNIT);
      DIR_LEFT:   o.normal_x = signed_field(1, UNIT);
      DIR_RIGHT:  o.normal_x = signed_field(0, UNIT);
      default: begin
        e1[0] = longint'(t.cx) - longint'(t.ax);
        e1[1] = longint'(t.cy) - longint'(t.ay);
        e1[2] = longint'(t.cz) - longint'(t.az);
        e2[0] = longint'(t.bx) - longint'(t.ax);
        e2[1] = longint'(t.by_coord) - longint'(t.ay);
        e2[2] = longint'(t.bz) - longint'(t.az);
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        m = 0;
        for (int i = 0; i < 3; i++) begin
          neg[i] = cr[i] < 0;
          mag[i] = neg[i] ? -cr[i] : cr[i];
          if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
          o.degenerate = 1'b1;
        end else begin
          bl = 0;
          while ((m >> bl) != 0) bl++;
          // Scale so the largest magnitude has exactly NORM_BITS bits.
          for (int i = 0; i < 3; i++) begin
            if (bl > NORM_BITS) mag[i] = mag[i] >> (bl - NORM_BITS);
            else mag[i] = mag[i] << (NORM_BITS - bl);
          end
          sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
          len = root_floor(sum);
          if (len == 0) len = 1;
          o.normal_x = '0;
          for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
            if (q > UNIT) q = UNIT;
            case (i)
              0: o.normal_x = signed_field(neg[i], q);
              1: o.normal_y = signed_field(neg[i], q);
              default: o.normal_z = signed_field(neg[i], q);
            endcase
          end
        end
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    tri_res_t w;
    if (!rst && start && !busy) expected_normals = {expected_normals, face_normal(req)};
    if (!rst && done) begin
      if (expected_normals.size() == 0) begin
        report_mismatch("result with no request waiting", 1, 0);
      end else begin
        w = expected_normals.pop_front();
        if (res.normal_x !== w.normal_x) report_mismatch("normal_x", res.normal_x, w.normal_x);
        if (res.normal_y !== w.normal_y) report_mismatch("normal_y", res.normal_y, w.normal_y);
        if (res.normal_z !== w.normal_z) report_mismatch("normal_z", res.normal_z, w.normal_z);
        if (res.degenerate !== w.degenerate)
          report_mismatch("degenerate", res.degenerate, w.degenerate);
      end
    end
    pending = expected_normals.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tfn_pkg::*;

  // Drain time allows for the block's pipeline with margin.
  localparam int DRAIN_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 200000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  logic     done;
  tri_req_t req;
  tri_res_t res;
  int       errors;
  int       pending;
  longint   cycles;
  int       idle_pct;

  triangle_face_normal dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res)
  );

  // The checker watches both channels and keeps the queue of expected normals.
  normal_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A cycle counter bounds the run in case the block hangs.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("triangle_face_normal regression: fail");
        $finish;
      end
    end
  end

  function automatic logic signed [COORD_WIDTH-1:0] random_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return COORD_WIDTH'($urandom_range(0, 15)) - 16'sd8;
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  // Sends one request: the request stays on the bus until it is taken.
  // With idling on, each cycle before it is left empty with the idle chance.
  // Called just after the clock rises; returns just after the request is accepted.
  task automatic send_request(tri_req_t t);
    while (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= t;
    do @(posedge clk); while (busy);
  endtask

  // Back-to-back requests keep start high: the edge that takes one request
  // also presents the next, so start is never lowered and raised in one step.
  task automatic send_burst(tri_req_t t);
    send_request(t);
  endtask

  function automatic tri_req_t random_triangle();
    tri_req_t t;
    t.ax = random_coord(); t.ay = random_coord(); t.az = random_coord();
    t.bx = random_coord(); t.by_coord = random_coord(); t.bz = random_coord();
    t.cx = random_coord(); t.cy = random_coord(); t.cz = random_coord();
    // Mostly computed normals, since that is where the arithmetic is.
    t.direction = ($urandom_range(0, 3) == 0) ? DIR_W'($urandom_range(0, 5))
                                               : DIR_W'($urandom_range(6, 7));
    if ($urandom_range(0, 15) == 0) begin
      // Collinear vertices give a degenerate triangle.
      t.cx = t.bx; t.cy = t.by_coord; t.cz = t.bz;
    end
    return t;
  endfunction

  initial begin
    tri_req_t t;
    int       phase_n;
    start = 1'b0;
    req = '0;
    rst = 1'b1;
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every axis code, both computed codes, degenerate triangles,
    // the coordinate extremes and an exact axis-aligned face.
    for (int d = 0; d < 8; d++) begin
      t = '0;
      t.bx = 16'sd256; t.cy = 16'sd256;
      t.direction = DIR_W'(d);
      send_burst(t);
    end
    t = '0; t.direction = 3'd6;
    send_burst(t);
    t = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
          16'sh7fff, 16'sh7fff, 16'sh7fff, 3'd7};
    send_burst(t);
    t = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh7fff, 16'sh8000, 3'd6};
    send_burst(t);
    t = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
          16'sh8000, 16'sh7fff, 16'sh7fff, 3'd6};
    send_burst(t);
    t = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh7fff, 16'sh7fff, 16'sh8000, 3'd7};
    send_burst(t);
    t = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 3'd6};
    send_burst(t);
    t = '{16'sd0, 16'sd0, 16'sd0, 16'sd2, 16'sd2, 16'sd2, 16'sd1, 16'sd1, 16'sd1, 3'd6};
    send_burst(t);
    t = '{16'shffff, 16'shffff, 16'shffff, 16'sh0000, 16'sh0000, 16'sh0000,
          16'sh5555, 16'shaaaa, 16'sh5555, 3'd6};
    send_burst(t);

    // Random phases: no idling, then a sender that idles more than half the time,
    // then light idling, then none. The receiver never stalls in this design.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: idle_pct = 0;
        1: idle_pct = 57;
        2: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      phase_n = 125;
      for (int i = 0; i < phase_n; i++) send_burst(random_triangle());
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("triangle_face_normal regression: pass");
    end else begin
      $display("triangle_face_normal regression: fail");
    end
    $finish;
  end

endmodule
